// ===== src/mtse_pkg.sv =====
// shared types, codes and constants of the modbus tcp server engine
package mtse_pkg;

  // default sizing
  localparam int DEF_TABLE_DEPTH    = 1024;
  localparam int DEF_MAX_DATA_BYTES = 32;

  // request frame layout: mbap header, function code, start, count, byte count
  localparam int HEAD_BYTES = 13;
  localparam int HDR_KEEP   = 12;

  // input actions
  localparam logic [1:0] ACT_FRAME  = 2'd0;
  localparam logic [1:0] ACT_SET_DI = 2'd1;
  localparam logic [1:0] ACT_SET_IR = 2'd2;

  // function codes
  localparam logic [7:0] FC_RD_COILS = 8'd1;
  localparam logic [7:0] FC_RD_DI    = 8'd2;
  localparam logic [7:0] FC_RD_HR    = 8'd3;
  localparam logic [7:0] FC_RD_IR    = 8'd4;
  localparam logic [7:0] FC_WR_COIL  = 8'd5;
  localparam logic [7:0] FC_WR_REG   = 8'd6;
  localparam logic [7:0] FC_WR_COILS = 8'd15;
  localparam logic [7:0] FC_WR_REGS  = 8'd16;

  // response status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_COIL     = 2'd2;
  localparam logic [1:0] ST_OVERSIZE = 2'd3;

  // coil on value, high byte
  localparam logic [7:0] COIL_ON = 8'hFF;

  // command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_SET_DI,
    CMD_SET_IR,
    CMD_REQUEST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [9:0]                addr;
    logic [15:0]               value;
    logic                      over;
    logic [HDR_KEEP-1:0][7:0]  hdr;
  } cmd_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic req_done;
  } bk_stat_t;

endpackage

// ===== src/mtse_queue.sv =====
// two-entry command queue between front and back end
module mtse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mtse_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output mtse_pkg::cmd_t  pop_data
);
  import mtse_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = ent_r[rp_r];

  // pointer and fill update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (pop) begin
      rp_nxt = ~rp_r;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== src/mtse_front.sv =====
// front end: takes input transfers, collects frames, queues commands
module mtse_front #(
  parameter int  MAX_DATA_BYTES = mtse_pkg::DEF_MAX_DATA_BYTES,
  localparam int DW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [7:0]          in_frame_byte,
  input  logic                in_frame_last,
  input  logic [9:0]          in_point_address,
  input  logic [15:0]         in_point_value,
  output logic                q_push,
  output mtse_pkg::cmd_t      q_data,
  input  logic                q_full,
  input  mtse_pkg::bk_stat_t  stat,
  input  logic [DW-1:0]       dm_raddr,
  output logic [7:0]          dm_rdata
);
  import mtse_pkg::*;

  localparam int STORE_DEPTH = HEAD_BYTES + MAX_DATA_BYTES;
  localparam int LW          = $clog2(STORE_DEPTH + 1);
  localparam logic [LW-1:0] STORE_LEN = LW'(STORE_DEPTH);
  localparam logic [LW-1:0] HEAD_LEN  = LW'(HEAD_BYTES);
  localparam logic [LW-1:0] KEEP_LEN  = LW'(HDR_KEEP);

  logic [7:0]               dmem [MAX_DATA_BYTES];
  logic [7:0]               dm_rdata_r;
  logic [HDR_KEEP-1:0][7:0] hdr_r;
  logic [HDR_KEEP-1:0][7:0] hdr_nxt;
  logic [LW-1:0]            len_r, len_nxt;
  logic                     over_r, over_nxt;
  logic                     req_pend_r, req_pend_nxt;
  logic                     accept;
  logic                     is_frame;
  logic                     room;
  logic                     dm_we;
  logic [LW-1:0]            dm_off;

  assign in_ready = !stat.clearing && !q_full && !req_pend_r;
  assign accept   = in_valid && in_ready;
  assign is_frame = (in_action == ACT_FRAME);
  assign room     = (len_r < STORE_LEN);
  assign dm_we    = accept && is_frame && room && (len_r >= HEAD_LEN);
  assign dm_off   = len_r - HEAD_LEN;

  // header bytes including the one on the port now
  always_comb begin
    hdr_nxt = hdr_r;
    if (accept && is_frame && room && (len_r < KEEP_LEN)) begin
      hdr_nxt[len_r[3:0]] = in_frame_byte;
    end
  end

  // command towards the back end
  always_comb begin
    q_push = accept && ((in_action == ACT_SET_DI) || (in_action == ACT_SET_IR) ||
                        (is_frame && in_frame_last));
    case (in_action)
      ACT_SET_DI: q_data.kind = CMD_SET_DI;
      ACT_SET_IR: q_data.kind = CMD_SET_IR;
      default:    q_data.kind = CMD_REQUEST;
    endcase
    q_data.addr  = in_point_address;
    q_data.value = in_point_value;
    q_data.over  = over_r || !room;
    q_data.hdr   = hdr_nxt;
  end

  // frame length, overflow and request pending
  always_comb begin
    len_nxt      = len_r;
    over_nxt     = over_r;
    req_pend_nxt = req_pend_r;
    if (stat.req_done) begin
      req_pend_nxt = 1'b0;
    end
    if (accept && is_frame) begin
      if (in_frame_last) begin
        len_nxt      = '0;
        over_nxt     = 1'b0;
        req_pend_nxt = 1'b1;
      end else if (room) begin
        len_nxt = len_r + LW'(1);
      end else begin
        over_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      over_r     <= 1'b0;
      req_pend_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      over_r     <= over_nxt;
      req_pend_r <= req_pend_nxt;
    end
  end

  // header bytes held until overwritten by a later frame
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  // frame data store
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_off[DW-1:0]] <= in_frame_byte;
    end
    dm_rdata_r <= dmem[dm_raddr];
  end

  assign dm_rdata = dm_rdata_r;

  // no transfer while a request is still with the back end
  a_pend_block: assert property (@(posedge clk) disable iff (!rst_n)
    req_pend_r |-> !in_ready)
    else $error("input ready while a request is pending");

  // the queue is never pushed when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // a last byte restarts frame collection
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_frame && in_frame_last) |=> (len_r == '0 && !over_r))
    else $error("frame length not restarted after last byte");

endmodule

// ===== src/mtse_back.sv =====
// back end: point tables, request execution and response streaming
module mtse_back #(
  parameter int  TABLE_DEPTH    = mtse_pkg::DEF_TABLE_DEPTH,
  parameter int  MAX_DATA_BYTES = mtse_pkg::DEF_MAX_DATA_BYTES,
  localparam int DW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  mtse_pkg::cmd_t      q_data,
  output mtse_pkg::bk_stat_t  stat,
  output logic [DW-1:0]       dm_raddr,
  input  logic [7:0]          dm_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_response_byte,
  output logic                out_response_last,
  output logic [1:0]          out_status
);
  import mtse_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(8 * MAX_DATA_BYTES + 1);
  localparam logic [16:0]   DEPTH17  = 17'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [13:0]   MAXD14   = 14'(MAX_DATA_BYTES);
  localparam logic [16:0]   MAXD17   = 17'(MAX_DATA_BYTES);
  localparam logic [15:0]   MAXR16   = 16'(MAX_DATA_BYTES / 2);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WM_RD,
    S_WM_HI,
    S_WM_WR,
    S_EMIT,
    S_FETCH
  } state_t;

  typedef enum logic [1:0] {
    M_FLAG,
    M_BITS,
    M_REGS,
    M_WRITE
  } mode_t;

  // point tables
  logic        coil_mem [TABLE_DEPTH];
  logic        di_mem   [TABLE_DEPTH];
  logic [15:0] hr_mem   [TABLE_DEPTH];
  logic [15:0] ir_mem   [TABLE_DEPTH];

  logic          coil_we, di_we, hr_we, ir_we;
  logic [AW-1:0] coil_wa, di_wa, hr_wa, ir_wa;
  logic          coil_wd, di_wd;
  logic [15:0]   hr_wd, ir_wd;
  logic [AW-1:0] rd_idx;
  logic          coil_rd_r, di_rd_r;
  logic [15:0]   hr_rd_r, ir_rd_r;

  state_t                   state_r, state_nxt;
  mode_t                    mode_r, mode_nxt;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic [HDR_KEEP-1:0][7:0] hdr_r, hdr_nxt;
  logic                     over_r, over_nxt;
  logic [PW-1:0]            p_r, p_nxt;
  logic [6:0]               len_r, len_nxt;
  logic [1:0]               status_r, status_nxt;
  logic                     inr_r, inr_nxt;
  logic [7:0]               rsp5_r, rsp5_nxt;
  logic [7:0]               rsp8_r, rsp8_nxt;
  logic [6:0]               idx_r, idx_nxt;
  logic [3:0]               bi_r, bi_nxt;
  logic [7:0]               dbyte_r, dbyte_nxt;
  logic [15:0]              word_r, word_nxt;
  logic                     byte_rdy_r, byte_rdy_nxt;
  logic [7:0]               hi_r, hi_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r, out_byte_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [1:0]               out_status_r, out_status_nxt;

  // request fields from the held header
  logic [7:0]  fc;
  logic [15:0] start;
  logic [15:0] cnt;
  logic [16:0] end17;
  logic        inrange;
  logic [13:0] nb_bits;
  logic [16:0] nb_regs;
  logic        coil_ok;
  logic        coil_on;

  assign fc      = hdr_r[7];
  assign start   = {hdr_r[8], hdr_r[9]};
  assign cnt     = {hdr_r[10], hdr_r[11]};
  assign end17   = {1'b0, start} + {1'b0, cnt};
  assign inrange = (cnt != 16'd0) && (end17 <= DEPTH17);
  assign nb_bits = 14'(({1'b0, cnt} + 17'd7) >> 3);
  assign nb_regs = {cnt, 1'b0};
  assign coil_on = (hdr_r[10] == COIL_ON) && (hdr_r[11] == 8'h00);
  assign coil_ok = coil_on || ((hdr_r[10] == 8'h00) && (hdr_r[11] == 8'h00));

  // addresses into the tables
  logic [6:0]  k;
  logic [8:0]  off;
  logic [16:0] ra17;
  logic [16:0] wa17;
  logic [16:0] ua17;
  logic [8:0]  cap_pos;
  logic [2:0]  cap_bit;
  logic        bit_rd;
  logic [15:0] reg_rd;
  logic        slot_free;
  logic        need_fetch;
  logic        is_data;
  logic [7:0]  byte_val;

  assign k       = idx_r - 7'd9;
  assign off     = (mode_r == M_BITS) ? {k[5:0], bi_r[2:0]} : 9'(k[6:1]);
  assign ra17    = {1'b0, start} + 17'(off);
  assign rd_idx  = ra17[AW-1:0];
  assign wa17    = {1'b0, start} + 17'(p_r);
  assign ua17    = 17'(q_data.addr);
  assign cap_bit = 3'(bi_r - 4'd1);
  assign cap_pos = {k[5:0], cap_bit};
  assign bit_rd  = (fc == FC_RD_COILS) ? coil_rd_r : di_rd_r;
  assign reg_rd  = (fc == FC_RD_HR) ? hr_rd_r : ir_rd_r;

  assign slot_free  = !out_valid_r || out_ready;
  assign is_data    = (idx_r >= 7'd9) && (mode_r == M_BITS || mode_r == M_REGS);
  assign need_fetch = is_data && inr_r && !byte_rdy_r &&
                      ((mode_r == M_BITS) || !k[0]);

  // response byte at the current index
  always_comb begin
    byte_val = 8'h00;
    if (mode_r == M_FLAG) begin
      byte_val = 8'h00;
    end else if (is_data) begin
      if (!inr_r) begin
        byte_val = 8'h00;
      end else if (mode_r == M_BITS) begin
        byte_val = dbyte_r;
      end else if (k[0]) begin
        byte_val = word_r[7:0];
      end else begin
        byte_val = word_r[15:8];
      end
    end else begin
      case (idx_r)
        7'd4:    byte_val = 8'h00;
        7'd5:    byte_val = rsp5_r;
        7'd8:    byte_val = (mode_r == M_WRITE) ? hdr_r[8] : rsp8_r;
        default: byte_val = hdr_r[idx_r[3:0]];
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    clr_nxt        = clr_r;
    hdr_nxt        = hdr_r;
    over_nxt       = over_r;
    p_nxt          = p_r;
    len_nxt        = len_r;
    status_nxt     = status_r;
    inr_nxt        = inr_r;
    rsp5_nxt       = rsp5_r;
    rsp8_nxt       = rsp8_r;
    idx_nxt        = idx_r;
    bi_nxt         = bi_r;
    dbyte_nxt      = dbyte_r;
    word_nxt       = word_r;
    byte_rdy_nxt   = byte_rdy_r;
    hi_nxt         = hi_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    stat.req_done  = 1'b0;
    stat.clearing  = (state_r == S_CLEAR);
    dm_raddr       = '0;
    coil_we = 1'b0; coil_wa = wa17[AW-1:0]; coil_wd = 1'b0;
    di_we   = 1'b0; di_wa   = ua17[AW-1:0]; di_wd   = q_data.value[0];
    hr_we   = 1'b0; hr_wa   = wa17[AW-1:0]; hr_wd   = cnt;
    ir_we   = 1'b0; ir_wa   = ua17[AW-1:0]; ir_wd   = q_data.value;
    case (state_r)
      S_CLEAR: begin
        coil_we = 1'b1; coil_wa = clr_r; coil_wd = 1'b0;
        di_we   = 1'b1; di_wa   = clr_r; di_wd   = 1'b0;
        hr_we   = 1'b1; hr_wa   = clr_r; hr_wd   = 16'h0000;
        ir_we   = 1'b1; ir_wa   = clr_r; ir_wd   = 16'h0000;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_data.kind)
            CMD_SET_DI: di_we = (ua17 < DEPTH17);
            CMD_SET_IR: ir_we = (ua17 < DEPTH17);
            default: begin
              hdr_nxt      = q_data.hdr;
              over_nxt     = q_data.over;
              p_nxt        = '0;
              idx_nxt      = '0;
              byte_rdy_nxt = 1'b0;
              state_nxt    = S_DECODE;
            end
          endcase
        end
      end
      S_DECODE: begin
        state_nxt  = S_EMIT;
        mode_nxt   = M_FLAG;
        len_nxt    = 7'd1;
        status_nxt = ST_OVERSIZE;
        inr_nxt    = inrange;
        if (!over_r) begin
          case (fc)
            FC_RD_COILS, FC_RD_DI: begin
              if (nb_bits <= MAXD14) begin
                mode_nxt   = M_BITS;
                len_nxt    = 7'd9 + 7'(nb_bits);
                rsp5_nxt   = 8'(nb_bits + 14'd3);
                rsp8_nxt   = 8'(nb_bits);
                status_nxt = inrange ? ST_OK : ST_RANGE;
              end
            end
            FC_RD_HR, FC_RD_IR: begin
              if (cnt <= MAXR16) begin
                mode_nxt   = M_REGS;
                len_nxt    = 7'd9 + 7'(nb_regs);
                rsp5_nxt   = 8'(nb_regs + 17'd3);
                rsp8_nxt   = 8'(nb_regs);
                status_nxt = inrange ? ST_OK : ST_RANGE;
              end
            end
            FC_WR_COIL, FC_WR_REG: begin
              mode_nxt = M_WRITE;
              len_nxt  = 7'd12;
              rsp5_nxt = 8'd6;
              if ({1'b0, start} >= DEPTH17) begin
                status_nxt = ST_RANGE;
              end else if (fc == FC_WR_REG) begin
                status_nxt = ST_OK;
                hr_we      = 1'b1;
              end else if (coil_ok) begin
                status_nxt = ST_OK;
                coil_we    = 1'b1;
                coil_wd    = coil_on;
              end else begin
                status_nxt = ST_COIL;
              end
            end
            FC_WR_COILS, FC_WR_REGS: begin
              if ((fc == FC_WR_COILS) ? (nb_bits <= MAXD14) : (nb_regs <= MAXD17)) begin
                mode_nxt   = M_WRITE;
                len_nxt    = 7'd12;
                rsp5_nxt   = 8'd6;
                status_nxt = inrange ? ST_OK : ST_RANGE;
                if (inrange) begin
                  state_nxt = S_WM_RD;
                end
              end
            end
            default: begin
              stat.req_done = 1'b1;
              state_nxt     = S_IDLE;
            end
          endcase
        end
      end
      S_WM_RD: begin
        if (fc == FC_WR_COILS) begin
          dm_raddr  = DW'(p_r >> 3);
          state_nxt = S_WM_WR;
        end else begin
          dm_raddr  = DW'({p_r, 1'b0});
          state_nxt = S_WM_HI;
        end
      end
      S_WM_HI: begin
        hi_nxt    = dm_rdata;
        dm_raddr  = DW'({p_r, 1'b1});
        state_nxt = S_WM_WR;
      end
      S_WM_WR: begin
        if (fc == FC_WR_COILS) begin
          coil_we = 1'b1;
          coil_wd = dm_rdata[p_r[2:0]];
        end else begin
          hr_we = 1'b1;
          hr_wd = {hi_r, dm_rdata};
        end
        p_nxt = p_r + PW'(1);
        if ((16'(p_r) + 16'd1) == cnt) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_WM_RD;
        end
      end
      S_EMIT: begin
        if (need_fetch) begin
          bi_nxt    = '0;
          dbyte_nxt = 8'h00;
          state_nxt = S_FETCH;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = byte_val;
          out_status_nxt = status_r;
          out_last_nxt   = (idx_r == len_r - 7'd1);
          byte_rdy_nxt   = 1'b0;
          idx_nxt        = idx_r + 7'd1;
          if (idx_r == len_r - 7'd1) begin
            stat.req_done = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        bi_nxt = bi_r + 4'd1;
        if (mode_r == M_BITS) begin
          if (bi_r != 4'd0 && (16'(cap_pos) < cnt)) begin
            dbyte_nxt[cap_bit] = bit_rd;
          end
          if (bi_r == 4'd8) begin
            byte_rdy_nxt = 1'b1;
            state_nxt    = S_EMIT;
          end
        end else if (bi_r != 4'd0) begin
          word_nxt     = reg_rd;
          byte_rdy_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      byte_rdy_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      byte_rdy_r   <= byte_rdy_nxt;
      mode_r       <= mode_nxt;
      hdr_r        <= hdr_nxt;
      over_r       <= over_nxt;
      p_r          <= p_nxt;
      len_r        <= len_nxt;
      status_r     <= status_nxt;
      inr_r        <= inr_nxt;
      rsp5_r       <= rsp5_nxt;
      rsp8_r       <= rsp8_nxt;
      idx_r        <= idx_nxt;
      bi_r         <= bi_nxt;
      dbyte_r      <= dbyte_nxt;
      word_r       <= word_nxt;
      hi_r         <= hi_nxt;
      out_byte_r   <= out_byte_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // table ports, one write and one registered read each
  always_ff @(posedge clk) begin
    if (coil_we) begin
      coil_mem[coil_wa] <= coil_wd;
    end
    coil_rd_r <= coil_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (di_we) begin
      di_mem[di_wa] <= di_wd;
    end
    di_rd_r <= di_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (hr_we) begin
      hr_mem[hr_wa] <= hr_wd;
    end
    hr_rd_r <= hr_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (ir_we) begin
      ir_mem[ir_wa] <= ir_wd;
    end
    ir_rd_r <= ir_mem[rd_idx];
  end

  assign out_valid         = out_valid_r;
  assign out_response_byte = out_byte_r;
  assign out_response_last = out_last_r;
  assign out_status        = out_status_r;

  // no command taken during the clearing pass
  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !q_pop)
    else $error("command popped during table clearing");

  // table fetches only for in-range reads
  a_fetch_inrange: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (inr_r && (mode_r == M_BITS || mode_r == M_REGS)))
    else $error("table fetch outside an in-range read");

  // an oversize flag is always a single-transfer response
  a_flag_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OVERSIZE) |-> out_last_r)
    else $error("oversize response longer than one transfer");

endmodule

// ===== src/modbus_tcp_server_engine.sv =====
// top level of the modbus tcp server engine
//
// Input channel (in_valid / in_ready): action 0 carries one request frame byte,
// with in_frame_last on the final byte; action 1 sets a discrete input and
// action 2 an input register at in_point_address. Field-side updates give no
// response. Output channel (out_valid / out_ready) streams the response bytes,
// out_response_last on the final one, out_status the same on every byte.
// Frame bytes are taken one per cycle while in_ready is high. Once a frame's last
// byte is in, input stays stalled until the whole response has been loaded into
// the output register: the request is decoded, then each header byte is loaded,
// each coil or discrete data byte after bit-serial table reads, each register
// after a table read; write-multiple requests first write their points.
// Field-side updates go through a two-entry command queue, one per cycle while
// in_ready is high. A stalled receiver holds the output register and in turn
// the sequencer. After reset all four point tables are cleared, one entry per
// cycle, and in_ready stays low until the pass is done.
// Oversize frames or requests give one byte, last set, status 3.
module modbus_tcp_server_engine #(
  parameter int TABLE_DEPTH    = mtse_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_DATA_BYTES = mtse_pkg::DEF_MAX_DATA_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  input  logic [9:0]  in_point_address,
  input  logic [15:0] in_point_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_response_byte,
  output logic        out_response_last,
  output logic [1:0]  out_status
);
  import mtse_pkg::*;

  localparam int DW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  cmd_t          q_in;
  cmd_t          q_out;
  bk_stat_t      stat;
  logic [DW-1:0] dm_raddr;
  logic [7:0]    dm_rdata;

  // frame collection and classification
  mtse_front #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_frame_byte    (in_frame_byte),
    .in_frame_last    (in_frame_last),
    .in_point_address (in_point_address),
    .in_point_value   (in_point_value),
    .q_push           (q_push),
    .q_data           (q_in),
    .q_full           (q_full),
    .stat             (stat),
    .dm_raddr         (dm_raddr),
    .dm_rdata         (dm_rdata)
  );

  // command queue
  mtse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  // execution and response
  mtse_back #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_data            (q_out),
    .stat              (stat),
    .dm_raddr          (dm_raddr),
    .dm_rdata          (dm_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_response_byte (out_response_byte),
    .out_response_last (out_response_last),
    .out_status        (out_status)
  );

endmodule
